### src/wbps_pkg.sv
package wbps_pkg;

	// Window depth and the widest pattern the block compares.
	localparam int MAX_PATTERN = 32;
	// Pattern bytes held by the four 64-bit registers.
	localparam int PAT_BYTES   = 32;
	localparam int PAT_REGS    = 4;
	localparam int IDX_W       = $clog2(PAT_BYTES);
	localparam int LEN_W       = 6;
	localparam int CNT_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WILD = 3'd5;

	// Pattern aligned to the shift window: apat[k] is compared with the
	// window byte k places back from the newest one; amask[k] is set where
	// that compare counts (inside the length and not a wildcard).
	typedef struct packed {
		logic [MAX_PATTERN-1:0][7:0] apat;
		logic [MAX_PATTERN-1:0]      amask;
		logic [IDX_W-1:0]            len_m1;
	} cfg_t;

endpackage

### src/wbps_if.sv
interface wbps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### src/wbps_cfg.sv
module wbps_cfg
	import wbps_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	wbps_cfg_if.sink      cfg_ch,
	output cfg_t          cfg_o
);

	logic [PAT_REGS-1:0][63:0]   pat_q;
	logic [IDX_W-1:0]            len_m1_q;
	logic [7:0]                  wild_q;
	logic [PAT_BYTES-1:0][7:0]   pat_bytes;
	logic                        wr;
	logic [LEN_W-1:0]            len_in;
	logic [MAX_PATTERN-1:0][7:0] apat_d;
	logic [MAX_PATTERN-1:0]      amask_d;
	logic [MAX_PATTERN-1:0][7:0] apat_q;
	logic [MAX_PATTERN-1:0]      amask_q;

	assign cfg_ch.ready = 1'b1;
	assign wr           = cfg_ch.valid & cfg_ch.ready;
	assign len_in       = cfg_ch.data[LEN_W-1:0];
	assign pat_bytes    = pat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q    <= '0;
			len_m1_q <= '0;
			wild_q   <= '0;
		end else if (wr) begin
			if (cfg_ch.index inside {[REG_PAT0:REG_PAT3]}) begin
				pat_q[cfg_ch.index[1:0]] <= cfg_ch.data;
			end else if (cfg_ch.index == REG_LEN) begin
				// clamp zero up to one and anything past the window down to it
				if (len_in == '0)
					len_m1_q <= '0;
				else if (len_in > LEN_W'(MAX_PATTERN))
					len_m1_q <= IDX_W'(MAX_PATTERN - 1);
				else
					len_m1_q <= IDX_W'(len_in - LEN_W'(1));
			end else if (cfg_ch.index == REG_WILD) begin
				wild_q <= cfg_ch.data[7:0];
			end
		end
	end

	// Reverse the pattern against the window: pattern byte len-1-k meets window byte k.
	always_comb begin
		logic [IDX_W-1:0] src;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			src        = len_m1_q - IDX_W'(k);
			apat_d[k]  = pat_bytes[src];
			amask_d[k] = (IDX_W'(k) <= len_m1_q) && (pat_bytes[src] != wild_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amask_q <= '0;
		end else begin
			amask_q <= amask_d;
		end
	end

	always_ff @(posedge clk) begin
		apat_q <= apat_d;
	end

	assign cfg_o.apat   = apat_q;
	assign cfg_o.amask  = amask_q;
	assign cfg_o.len_m1 = len_m1_q;

endmodule

### src/wildcard_byte_pattern_search.sv
// Channel | Role  | Payload                       | Word accepted when
// in_ch   | sink  | data_byte[7:0], last_byte     | valid & ready
// out_ch  | src   | found, match_offset[31:0]     | valid & ready
// cfg_ch  | sink  | index[2:0], data[63:0]        | valid & ready (ready always high)
//
// One byte per cycle sustained while no result waits on a stalled output; an accepted
// byte passes the input register, the window compare and then the result register.
// The compare is a 32-byte parallel match against a pattern pre-aligned to the
// window; the aligned copy is registered again from the configuration registers.
// Reset clears the stream state and the configuration registers (pattern length one).
// A stalled result holds the byte in the input register only if that byte
// itself has a result to give; otherwise bytes keep flowing.
module wildcard_byte_pattern_search
	import wbps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	wbps_in_if.sink  in_ch,
	wbps_out_if.source out_ch,
	wbps_cfg_if.sink cfg_ch
);

	cfg_t cfg;

	wbps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg_o  (cfg)
	);

	// Input register.
	logic       s1_valid_q;
	logic [7:0] data_s1;
	logic       last_s1;

	// Stream state.
	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [MAX_PATTERN-1:0][7:0] win_new;
	logic [CNT_W-1:0]            cnt_q;
	logic                        reported_q;

	// Result register.
	logic             out_valid_q;
	logic             found_q;
	logic [CNT_W-1:0] offset_q;

	logic             in_acc;
	logic             out_free;
	logic             s1_adv;
	logic             emit;
	logic             match;
	logic             len_ok;
	logic [MAX_PATTERN-1:0] hit;
	logic [CNT_W-1:0] len_m1_ext;

	assign in_acc     = in_ch.valid & in_ch.ready;
	assign out_free   = !out_valid_q || out_ch.ready;
	assign len_m1_ext = CNT_W'(cfg.len_m1);

	// Window as it stands once the current byte is shifted in.
	always_comb begin
		win_new[0] = data_s1;
		for (int k = 1; k < MAX_PATTERN; k++)
			win_new[k] = win_q[k-1];
	end

	// Every byte position either matches, is a wildcard or lies past the length.
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++)
			hit[k] = !cfg.amask[k] || (cfg.apat[k] == win_new[k]);
	end

	assign len_ok = cnt_q >= len_m1_ext;
	assign match  = (&hit) && len_ok && !reported_q;
	// One result per buffer: the first match, or the last byte with no match.
	assign emit   = s1_valid_q && (match || (last_s1 && !reported_q));
	// Advance the input register unless its result has nowhere to go.
	assign s1_adv = s1_valid_q && (!emit || out_free);

	assign in_ch.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// Window bytes older than the buffer start are never compared: the length
	// check keeps them out, so the window needs no clearing.
	always_ff @(posedge clk) begin
		if (s1_adv)
			win_q <= win_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				// end of buffer: drop the stream state
				cnt_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				if (cnt_q != '1)
					cnt_q <= cnt_q + CNT_W'(1);
				if (match)
					reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			found_q  <= match;
			offset_q <= match ? (cnt_q - len_m1_ext) : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found        = found_q;
	assign out_ch.match_offset = offset_q;

`ifndef ASSERT_OFF
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> offset_q == '0)
		else $error("not-found result with nonzero offset");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> cnt_q == '0 && !reported_q)
		else $error("stream state not cleared after last byte");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && reported_q |-> !emit)
		else $error("second result in one buffer");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && emit && !out_free |=> s1_valid_q && $stable(data_s1))
		else $error("byte with a result dropped while output stalled");
`endif

endmodule
